@@ src/sedge_pkg.sv @@
package sedge_pkg;

  // Default frame store limits.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Field widths fixed by the item formats.
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 11;
  localparam int CFG_SIZE_W = 12;
  localparam int THR_W      = 8;
  localparam int GRAD_W     = 10;

  // Configuration port.
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd3;

  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH    = 12'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT   = 12'd480;
  localparam logic [THR_W-1:0]      RST_HIGH_THRESHOLD = 8'd200;
  localparam logic [THR_W-1:0]      RST_LOW_THRESHOLD  = 8'd100;

  // Smallest frame side the filter works on.
  localparam int MIN_SIZE = 3;

  // Result queue depth; one input can add up to three results.
  localparam int Q_DEPTH     = 8;
  localparam int MAX_RESULTS = 3;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [GRAD_W-1:0]  grad_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } in_item_t;

  typedef struct packed {
    coord_t out_row;
    coord_t out_col;
    pix_t   edge_value;
    logic   frame_last;
  } out_item_t;

  // Two line store entries kept at one address.
  typedef struct packed {
    pix_t newer;
    pix_t older;
  } line_pair_t;

  // One window column: two rows above and the current row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Which results an item causes, and their coordinates.
  typedef struct packed {
    logic   e_inner;
    logic   e_right;
    logic   e_bottom;
    logic   computed;
    logic   last;
    coord_t row_a;
    coord_t col_a;
    coord_t col_b;
    coord_t row_c;
    coord_t col_c;
  } res_info_t;

  typedef struct packed {
    logic room;
  } q_stat_t;

endpackage

@@ src/sedge_line_store.sv @@
module sedge_line_store #(
  parameter int DEPTH = sedge_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  sedge_pkg::line_pair_t  wr_data,
  output sedge_pkg::line_pair_t  rd_data
);
  import sedge_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t rd_q;
  line_pair_t byp_data;
  logic       byp;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same address in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

@@ src/sedge_col_cell.sv @@
module sedge_col_cell (
  input  logic            clk,
  input  logic            shift,
  input  sedge_pkg::col_t col_in,
  output sedge_pkg::col_t col_out
);
  import sedge_pkg::*;

  col_t col;

  // Take the neighbor's column whenever the window moves one pixel on.
  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

@@ src/sedge_gradient.sv @@
module sedge_gradient (
  input  logic             clk,
  input  logic             en,
  input  sedge_pkg::col_t  left,
  input  sedge_pkg::col_t  center,
  input  sedge_pkg::col_t  right,
  output sedge_pkg::grad_t gx_abs,
  output sedge_pkg::grad_t gy_abs
);
  import sedge_pkg::*;

  grad_t sum_right;
  grad_t sum_left;
  grad_t sum_top;
  grad_t sum_bot;

  // Weighted sum a + 2b + c of three pixels.
  function automatic grad_t wsum(pix_t a, pix_t b, pix_t c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  always_comb begin
    sum_right = wsum(right.top, right.mid, right.bot);
    sum_left  = wsum(left.top, left.mid, left.bot);
    sum_top   = wsum(left.top, center.top, right.top);
    sum_bot   = wsum(left.bot, center.bot, right.bot);
  end

  // Magnitudes of both gradients, taken as larger minus smaller.
  always_ff @(posedge clk) begin
    if (en) begin
      gx_abs <= (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
      gy_abs <= (sum_top >= sum_bot) ? sum_top - sum_bot : sum_bot - sum_top;
    end
  end

endmodule

@@ src/sedge_result_queue.sv @@
module sedge_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sedge_pkg::res_info_t info,
  input  sedge_pkg::pix_t      value,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sedge_pkg::out_item_t res_data,
  output sedge_pkg::q_stat_t   stat
);
  import sedge_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  out_item_t            q [Q_DEPTH];
  out_item_t            slot [MAX_RESULTS];
  out_item_t            res_inner;
  out_item_t            res_right;
  out_item_t            res_bottom;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           n_push;
  logic                 pop;

  // Build the up to three results of one item and pack them in order.
  always_comb begin
    res_inner  = '{out_row: info.row_a, out_col: info.col_a,
                   edge_value: info.computed ? value : '0, frame_last: 1'b0};
    res_right  = '{out_row: info.row_a, out_col: info.col_b,
                   edge_value: '0, frame_last: 1'b0};
    res_bottom = '{out_row: info.row_c, out_col: info.col_c,
                   edge_value: '0, frame_last: info.last};
    slot[0] = info.e_inner ? res_inner : (info.e_right ? res_right : res_bottom);
    slot[1] = (info.e_inner && info.e_right) ? res_right : res_bottom;
    slot[2] = res_bottom;
    n_push  = push ? ({1'b0, info.e_inner} + {1'b0, info.e_right} + {1'b0, info.e_bottom})
                   : 2'd0;
  end

  assign pop        = res_ready && (count != '0);
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);

  // Storage.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (k < int'(n_push)) begin
        q[tail + PTR_W'(k)] <= slot[k];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(pop);
      tail  <= tail + PTR_W'(n_push);
      count <= count_next;
    end
  end

  assign res_valid  = (count != '0);
  assign res_data   = q[head];
  assign stat.room  = (count <= CNT_W'(Q_DEPTH - MAX_RESULTS));

endmodule

@@ src/sobel_edge_threshold_filter.sv @@
// Streaming 3x3 Sobel edge filter. Grey pixels enter in raster order, one per clock, and each
// result leaves as an item with its row and column; the value is 255 minus the low byte of
// |Gx|+|Gy|, forced to 255 above high_threshold and to 0 below low_threshold, and border pixels
// give 0. A pixel is taken every cycle while the eight-entry result queue has room for three
// more results; pixels in the last column or the last row can add two or three results, so a
// steady stream at one result per clock can pause the input at such pixels. A pixel passes the
// registers s1, s2 and s3 and the result queue before its first result leaves. The two line
// stores share one memory with one read and one write port, and each pixel does one of each.
module sobel_edge_threshold_filter #(
  parameter int MAX_WIDTH  = sedge_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sedge_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          px_valid,
  output logic                          px_ready,
  input  sedge_pkg::in_item_t           px_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output sedge_pkg::out_item_t          res_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sedge_pkg::APB_AW-1:0]  paddr,
  input  logic [sedge_pkg::APB_DW-1:0]  pwdata,
  output logic [sedge_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import sedge_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SZ_W = CFG_SIZE_W + 1;
  localparam logic [CW-1:0] W_LAST_MAX = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] H_LAST_MAX = RW'(MAX_HEIGHT - 1);
  localparam logic [CW-1:0] W_LAST_MIN = CW'(MIN_SIZE - 1);
  localparam logic [RW-1:0] H_LAST_MIN = RW'(MIN_SIZE - 1);

  logic [CFG_SIZE_W-1:0] frame_width;
  logic [CFG_SIZE_W-1:0] frame_height;
  logic [THR_W-1:0]      high_threshold;
  logic [THR_W-1:0]      low_threshold;
  logic [REG_IDX_W-1:0]  reg_idx;

  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [CW-1:0] col_pos;
  logic [CW-1:0] col_pos_next;
  logic [RW-1:0] row_pos;
  logic [RW-1:0] row_pos_next;
  logic          restart;
  logic [CW-1:0] cur_c;
  logic [RW-1:0] cur_r;

  logic      adv;
  logic      px_fire;
  res_info_t info0;
  logic      s1_valid;
  logic      s2_valid;
  logic      s3_valid;
  res_info_t s1_info;
  res_info_t s2_info;
  res_info_t s3_info;
  pix_t      s1_px;
  logic [CW-1:0] s1_c;

  line_pair_t above;
  line_pair_t line_wr;
  col_t       col_new;
  col_t       col_left;
  col_t       col_center;
  col_t       col_right;
  logic       shift;
  grad_t      gx_abs;
  grad_t      gy_abs;
  pix_t       grad_low;
  pix_t       inv_value;
  pix_t       edge_out;
  q_stat_t    q_stat;

  // Configuration registers.
  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      high_threshold <= RST_HIGH_THRESHOLD;
      low_threshold  <= RST_LOW_THRESHOLD;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FRAME_WIDTH:    frame_width    <= pwdata[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[CFG_SIZE_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold <= pwdata[THR_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:    prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT:   prdata = APB_DW'(frame_height);
      REG_HIGH_THRESHOLD: prdata = APB_DW'(high_threshold);
      REG_LOW_THRESHOLD:  prdata = APB_DW'(low_threshold);
      default:            prdata = '0;
    endcase
  end

  // Frame sizes clamped to the supported range, held as last index.
  always_comb begin
    if (frame_width < CFG_SIZE_W'(MIN_SIZE)) begin
      w_last = W_LAST_MIN;
    end else if ({1'b0, frame_width} > SZ_W'(MAX_WIDTH)) begin
      w_last = W_LAST_MAX;
    end else begin
      w_last = CW'(frame_width - CFG_SIZE_W'(1));
    end
    if (frame_height < CFG_SIZE_W'(MIN_SIZE)) begin
      h_last = H_LAST_MIN;
    end else if ({1'b0, frame_height} > SZ_W'(MAX_HEIGHT)) begin
      h_last = H_LAST_MAX;
    end else begin
      h_last = RW'(frame_height - CFG_SIZE_W'(1));
    end
  end

  // Position of the incoming pixel and the position after it.
  always_comb begin
    restart = px_data.frame_start || (row_pos > h_last) || (col_pos > w_last);
    cur_r   = restart ? '0 : row_pos;
    cur_c   = restart ? '0 : col_pos;
    if (cur_c == w_last) begin
      col_pos_next = '0;
      row_pos_next = (cur_r == h_last) ? '0 : cur_r + RW'(1);
    end else begin
      col_pos_next = cur_c + CW'(1);
      row_pos_next = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (px_fire) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // Results that this pixel causes.
  always_comb begin
    info0.e_inner  = (cur_r != '0) && (cur_c != '0);
    info0.e_right  = (cur_r != '0) && (cur_c == w_last);
    info0.e_bottom = (cur_r == h_last);
    info0.computed = (cur_r > RW'(1)) && (cur_c > CW'(1));
    info0.last     = (cur_c == w_last);
    info0.row_a    = COORD_W'(cur_r - RW'(1));
    info0.col_a    = COORD_W'(cur_c - CW'(1));
    info0.col_b    = COORD_W'(w_last);
    info0.row_c    = COORD_W'(h_last);
    info0.col_c    = COORD_W'(cur_c);
  end

  // The whole pipeline moves while the result queue can absorb a full item.
  assign adv      = q_stat.room;
  assign px_ready = adv;
  assign px_fire  = px_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= px_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_info <= info0;
      s1_px   <= px_data.pixel;
      s1_c    <= cur_c;
      s2_info <= s1_info;
      s3_info <= s2_info;
    end
  end

  // Line stores: the older row takes the newer one, the newer row takes the pixel.
  assign line_wr = '{newer: s1_px, older: above.newer};
  assign shift   = adv && s1_valid;

  sedge_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (px_fire),
    .rd_addr (cur_c),
    .wr_en   (shift),
    .wr_addr (s1_c),
    .wr_data (line_wr),
    .rd_data (above)
  );

  // Window: three column cells, the newest column enters on the right.
  assign col_new = '{top: above.older, mid: above.newer, bot: s1_px};

  sedge_col_cell u_cell_right (
    .clk     (clk),
    .shift   (shift),
    .col_in  (col_new),
    .col_out (col_right)
  );

  sedge_col_cell u_cell_center (
    .clk     (clk),
    .shift   (shift),
    .col_in  (col_right),
    .col_out (col_center)
  );

  sedge_col_cell u_cell_left (
    .clk     (clk),
    .shift   (shift),
    .col_in  (col_center),
    .col_out (col_left)
  );

  sedge_gradient u_gradient (
    .clk    (clk),
    .en     (adv && s2_valid),
    .left   (col_left),
    .center (col_center),
    .right  (col_right),
    .gx_abs (gx_abs),
    .gy_abs (gy_abs)
  );

  // Wrap to a byte, invert and threshold.
  always_comb begin
    grad_low  = gx_abs[PIX_W-1:0] + gy_abs[PIX_W-1:0];
    inv_value = ~grad_low;
    if (inv_value > high_threshold) begin
      edge_out = '1;
    end else if (inv_value < low_threshold) begin
      edge_out = '0;
    end else begin
      edge_out = inv_value;
    end
  end

  sedge_result_queue u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && s3_valid),
    .info      (s3_info),
    .value     (edge_out),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .stat      (q_stat)
  );

`ifndef SYNTHESIS
  // A frame start always places the pixel in the first column.
  a_frame_start_col: assert property (@(posedge clk) disable iff (rst)
    px_fire && px_data.frame_start |=> s1_valid && (s1_c == '0))
    else $error("frame start pixel not at column zero");

  // A computed result only ever belongs to an inner pixel.
  a_computed_inner: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_info.computed |-> s3_info.e_inner)
    else $error("computed result without inner position");

  // Results only disappear from the output when one is taken.
  a_res_valid_drop: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(res_valid) |-> $past(res_ready))
    else $error("result valid dropped without acceptance");
`endif

endmodule
